>>> sv/sphere_capsule_contact_core_assert.svh
// assertion macros for the sphere capsule contact core
// used by the port checker, no other dependencies
`ifndef SPHERE_CAPSULE_CONTACT_CORE_ASSERT_SVH
`define SPHERE_CAPSULE_CONTACT_CORE_ASSERT_SVH

// condition that holds on every clock out of reset
`define SCC_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked on every clock out of reset
`define SCC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> sv/scc_pkg.sv
// shared types and constants for the sphere capsule contact core
// no dependencies
package scc_pkg;

  localparam int COORD_W_DEF = 32;
  localparam int FRAC_DEF    = 16;
  localparam int LEN_W       = 31;
  localparam int SUM_W       = LEN_W + 1;
  localparam int THR_W       = 17;
  localparam int RAD_W       = 2 * SUM_W;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  typedef enum logic [1:0] {
    FUNC_SS = 2'd0,
    FUNC_SC = 2'd1,
    FUNC_CS = 2'd2,
    FUNC_CC = 2'd3
  } scc_func_t;

  typedef struct packed {
    logic             hit;
    logic             sx;
    logic             sy;
    logic             sz;
    logic [SUM_W-1:0] ux;
    logic [SUM_W-1:0] uy;
    logic [SUM_W-1:0] uz;
    logic [SUM_W-1:0] sumr;
  } scc_side_t;

endpackage

>>> sv/sphere_capsule_contact_core.sv
// path: front end, square root, three-lane divider and output register
// throughput: one word per cycle; busy stays low and cfg_ready stays high
// the rate is set by the fully pipelined square root and three-lane divider
// the receiver cannot stall: each result is shown for one cycle with out_valid
// synchronous active-low reset clears the valid bits and sets the threshold to 1
module sphere_capsule_contact_core import scc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_func,
  input  logic signed [COORD_WIDTH-1:0] in_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_a_z,
  input  logic [LEN_W-1:0]              in_a_radius,
  input  logic [LEN_W-1:0]              in_a_length,
  input  logic signed [COORD_WIDTH-1:0] in_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_b_z,
  input  logic [LEN_W-1:0]              in_b_radius,
  input  logic [LEN_W-1:0]              in_b_length,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [THR_W-1:0]              cfg_data,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [FRAC_BITS+1:0]   out_normal_x,
  output logic signed [FRAC_BITS+1:0]   out_normal_y,
  output logic signed [FRAC_BITS+1:0]   out_normal_z,
  output logic [LEN_W-1:0]              out_depth
);

  localparam int NW = FRAC_BITS + 2;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  logic             fr_v;
  logic [RAD_W-1:0] fr_rad;
  scc_side_t        fr_side;

  scc_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start && !busy),
    .func     (in_func),
    .a_x      (in_a_x),
    .a_y      (in_a_y),
    .a_z      (in_a_z),
    .a_radius (in_a_radius),
    .a_length (in_a_length),
    .b_x      (in_b_x),
    .b_y      (in_b_y),
    .b_z      (in_b_z),
    .b_radius (in_b_radius),
    .b_length (in_b_length),
    .thr      (thr_r),
    .out_valid(fr_v),
    .out_rad  (fr_rad),
    .out_side (fr_side)
  );

  logic             sq_v;
  logic [SUM_W-1:0] sq_root;
  scc_side_t        sq_side;

  scc_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (fr_v),
    .in_rad   (fr_rad),
    .in_side  (fr_side),
    .out_valid(sq_v),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  logic               dv_v;
  logic [SUM_W-1:0]   dv_dist;
  logic [FRAC_BITS:0] dv_qx, dv_qy, dv_qz;
  scc_side_t          dv_side;

  scc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (sq_v),
    .in_dist  (sq_root),
    .in_side  (sq_side),
    .out_valid(dv_v),
    .out_dist (dv_dist),
    .out_qx   (dv_qx),
    .out_qy   (dv_qy),
    .out_qz   (dv_qz),
    .out_side (dv_side)
  );

  function automatic logic [NW-1:0] apply_sign(input logic [FRAC_BITS:0] q, input logic neg);
    logic [NW-1:0] m;
    m = {1'b0, q};
    return neg ? -m : m;
  endfunction

  logic [SUM_W-1:0] pen_diff;
  logic             zero_dist;
  assign pen_diff  = dv_side.sumr - dv_dist;
  assign zero_dist = dv_dist == '0;

  logic                 out_valid_r, out_hit_r;
  logic [NW-1:0]        nx_r, ny_r, nz_r;
  logic [LEN_W-1:0]     pen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v;
    end
    out_hit_r <= dv_side.hit;
    if (!dv_side.hit) begin
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= '0;
      pen_r <= '0;
    end else begin
      if (zero_dist) begin
        nx_r <= '0;
        ny_r <= '0;
        nz_r <= {2'b01, {FRAC_BITS{1'b0}}};
      end else begin
        nx_r <= apply_sign(dv_qx, dv_side.sx);
        ny_r <= apply_sign(dv_qy, dv_side.sy);
        nz_r <= apply_sign(dv_qz, dv_side.sz);
      end
      pen_r <= pen_diff[SUM_W-1] ? {LEN_W{1'b1}} : pen_diff[LEN_W-1:0];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_normal_z = nz_r;
  assign out_depth    = pen_r;

endmodule

>>> sv/scc_front.sv
// geometry front end: swap, segment ends, clamping, distance and overlap test
// depends on scc_pkg
module scc_front import scc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [1:0]                    func,
  input  logic signed [COORD_WIDTH-1:0] a_x,
  input  logic signed [COORD_WIDTH-1:0] a_y,
  input  logic signed [COORD_WIDTH-1:0] a_z,
  input  logic [LEN_W-1:0]              a_radius,
  input  logic [LEN_W-1:0]              a_length,
  input  logic signed [COORD_WIDTH-1:0] b_x,
  input  logic signed [COORD_WIDTH-1:0] b_y,
  input  logic signed [COORD_WIDTH-1:0] b_z,
  input  logic [LEN_W-1:0]              b_radius,
  input  logic [LEN_W-1:0]              b_length,
  input  logic [THR_W-1:0]              thr,
  output logic                          out_valid,
  output logic [RAD_W-1:0]              out_rad,
  output scc_side_t                     out_side
);

  localparam int CW = COORD_WIDTH;
  localparam int ZW = ((CW > LEN_W) ? CW : LEN_W) + 2;
  localparam int MW = ZW + 1;
  localparam int L2 = 2 * LEN_W;

  function automatic logic signed [ZW-1:0] clampz(input logic signed [ZW-1:0] v,
                                                  input logic signed [ZW-1:0] lo,
                                                  input logic signed [ZW-1:0] hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // stage 1
  logic                   sw, capa, capb;
  logic signed [CW-1:0]   pax, pay, paz, pbx, pby, pbz;
  logic [LEN_W-1:0]       par, pal, pbr, pbl, la, lb;
  logic signed [ZW-1:0]   sa_nxt, ea_nxt, sb_nxt, eb_nxt;

  assign sw   = func == FUNC_CS;
  assign capa = func == FUNC_CC;
  assign capb = func != FUNC_SS;
  assign pax  = sw ? b_x : a_x;
  assign pay  = sw ? b_y : a_y;
  assign paz  = sw ? b_z : a_z;
  assign pbx  = sw ? a_x : b_x;
  assign pby  = sw ? a_y : b_y;
  assign pbz  = sw ? a_z : b_z;
  assign par  = sw ? b_radius : a_radius;
  assign pbr  = sw ? a_radius : b_radius;
  assign pal  = sw ? b_length : a_length;
  assign pbl  = sw ? a_length : b_length;
  assign la   = capa ? pal : '0;
  assign lb   = capb ? pbl : '0;

  assign sa_nxt = $signed({{(ZW-CW){paz[CW-1]}}, paz})
                - $signed({{(ZW-LEN_W+1){1'b0}}, la[LEN_W-1:1]});
  assign ea_nxt = sa_nxt + $signed({{(ZW-LEN_W){1'b0}}, la});
  assign sb_nxt = $signed({{(ZW-CW){pbz[CW-1]}}, pbz})
                - $signed({{(ZW-LEN_W+1){1'b0}}, lb[LEN_W-1:1]});
  assign eb_nxt = sb_nxt + $signed({{(ZW-LEN_W){1'b0}}, lb});

  logic                 s1_v_r;
  logic signed [ZW-1:0] s1_sa_r, s1_ea_r, s1_sb_r, s1_eb_r;
  logic [L2-1:0]        s1_la2_r, s1_lb2_r;
  logic signed [CW:0]   s1_dx_r, s1_dy_r;
  logic [SUM_W-1:0]     s1_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_valid;
    end
    s1_sa_r   <= sa_nxt;
    s1_ea_r   <= ea_nxt;
    s1_sb_r   <= sb_nxt;
    s1_eb_r   <= eb_nxt;
    s1_la2_r  <= L2'(la) * L2'(la);
    s1_lb2_r  <= L2'(lb) * L2'(lb);
    s1_dx_r   <= {pbx[CW-1], pbx} - {pax[CW-1], pax};
    s1_dy_r   <= {pby[CW-1], pby} - {pay[CW-1], pay};
    s1_sumr_r <= {1'b0, par} + {1'b0, pbr};
  end

  // stage 2: degenerate tests and clamp candidates
  logic [L2-1:0] lim;
  assign lim = {{(L2-THR_W-FRAC_BITS){1'b0}}, thr, {FRAC_BITS{1'b0}}};

  logic                 s2_v_r, s2_dega_r, s2_degb_r;
  logic signed [ZW-1:0] s2_sa_r, s2_ea_r, s2_sb_r, s2_c1_r, s2_c2_r;
  logic signed [CW:0]   s2_dx_r, s2_dy_r;
  logic [SUM_W-1:0]     s2_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_dega_r <= s1_la2_r <= lim;
    s2_degb_r <= s1_lb2_r <= lim;
    s2_c1_r   <= clampz(s1_sa_r, s1_sb_r, s1_eb_r);
    s2_c2_r   <= clampz(s1_sb_r, s1_sa_r, s1_ea_r);
    s2_sa_r   <= s1_sa_r;
    s2_ea_r   <= s1_ea_r;
    s2_sb_r   <= s1_sb_r;
    s2_dx_r   <= s1_dx_r;
    s2_dy_r   <= s1_dy_r;
    s2_sumr_r <= s1_sumr_r;
  end

  // stage 3: closest points on the axes
  logic signed [ZW-1:0] ca_nxt, cb_nxt;

  always_comb begin
    if (s2_dega_r) begin
      ca_nxt = s2_sa_r;
      cb_nxt = s2_degb_r ? s2_sb_r : s2_c1_r;
    end else if (s2_degb_r) begin
      cb_nxt = s2_sb_r;
      ca_nxt = s2_c2_r;
    end else begin
      cb_nxt = s2_c1_r;
      ca_nxt = clampz(s2_c1_r, s2_sa_r, s2_ea_r);
    end
  end

  logic                 s3_v_r;
  logic signed [ZW-1:0] s3_ca_r, s3_cb_r;
  logic signed [CW:0]   s3_dx_r, s3_dy_r;
  logic [SUM_W-1:0]     s3_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_ca_r   <= ca_nxt;
    s3_cb_r   <= cb_nxt;
    s3_dx_r   <= s2_dx_r;
    s3_dy_r   <= s2_dy_r;
    s3_sumr_r <= s2_sumr_r;
  end

  // stage 4: deltas and magnitudes
  logic signed [ZW:0] dz;
  logic [CW:0]        mx, my;
  logic [ZW:0]        mz;

  assign dz = {s3_cb_r[ZW-1], s3_cb_r} - {s3_ca_r[ZW-1], s3_ca_r};
  assign mx = s3_dx_r[CW] ? -s3_dx_r : s3_dx_r;
  assign my = s3_dy_r[CW] ? -s3_dy_r : s3_dy_r;
  assign mz = dz[ZW] ? -dz : dz;

  logic             s4_v_r, s4_sx_r, s4_sy_r, s4_sz_r;
  logic [MW-1:0]    s4_ux_r, s4_uy_r, s4_uz_r;
  logic [SUM_W-1:0] s4_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_sx_r   <= s3_dx_r[CW];
    s4_sy_r   <= s3_dy_r[CW];
    s4_sz_r   <= dz[ZW];
    s4_ux_r   <= {{(MW-CW-1){1'b0}}, mx};
    s4_uy_r   <= {{(MW-CW-1){1'b0}}, my};
    s4_uz_r   <= mz;
    s4_sumr_r <= s3_sumr_r;
  end

  // stage 5: per-axis reject
  logic [MW-1:0] sumr_w;
  assign sumr_w = {{(MW-SUM_W){1'b0}}, s4_sumr_r};

  logic             s5_v_r, s5_far_r, s5_sx_r, s5_sy_r, s5_sz_r;
  logic [SUM_W-1:0] s5_ux_r, s5_uy_r, s5_uz_r, s5_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else begin
      s5_v_r <= s4_v_r;
    end
    s5_far_r  <= (s4_ux_r > sumr_w) || (s4_uy_r > sumr_w) || (s4_uz_r > sumr_w);
    s5_ux_r   <= s4_ux_r[SUM_W-1:0];
    s5_uy_r   <= s4_uy_r[SUM_W-1:0];
    s5_uz_r   <= s4_uz_r[SUM_W-1:0];
    s5_sx_r   <= s4_sx_r;
    s5_sy_r   <= s4_sy_r;
    s5_sz_r   <= s4_sz_r;
    s5_sumr_r <= s4_sumr_r;
  end

  // stage 6: squares
  logic             s6_v_r, s6_far_r, s6_sx_r, s6_sy_r, s6_sz_r;
  logic [RAD_W-1:0] s6_qx_r, s6_qy_r, s6_qz_r, s6_qr_r;
  logic [SUM_W-1:0] s6_ux_r, s6_uy_r, s6_uz_r, s6_sumr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_v_r <= 1'b0;
    end else begin
      s6_v_r <= s5_v_r;
    end
    s6_qx_r   <= RAD_W'(s5_ux_r) * RAD_W'(s5_ux_r);
    s6_qy_r   <= RAD_W'(s5_uy_r) * RAD_W'(s5_uy_r);
    s6_qz_r   <= RAD_W'(s5_uz_r) * RAD_W'(s5_uz_r);
    s6_qr_r   <= RAD_W'(s5_sumr_r) * RAD_W'(s5_sumr_r);
    s6_far_r  <= s5_far_r;
    s6_ux_r   <= s5_ux_r;
    s6_uy_r   <= s5_uy_r;
    s6_uz_r   <= s5_uz_r;
    s6_sx_r   <= s5_sx_r;
    s6_sy_r   <= s5_sy_r;
    s6_sz_r   <= s5_sz_r;
    s6_sumr_r <= s5_sumr_r;
  end

  // stage 7: squared distance and overlap test
  logic [RAD_W+1:0] d2;
  assign d2 = {2'b00, s6_qx_r} + {2'b00, s6_qy_r} + {2'b00, s6_qz_r};

  logic             s7_v_r;
  logic [RAD_W-1:0] s7_rad_r;
  scc_side_t        s7_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else begin
      s7_v_r <= s6_v_r;
    end
    s7_rad_r       <= d2[RAD_W-1:0];
    s7_side_r.hit  <= !s6_far_r && (d2 <= {2'b00, s6_qr_r});
    s7_side_r.sx   <= s6_sx_r;
    s7_side_r.sy   <= s6_sy_r;
    s7_side_r.sz   <= s6_sz_r;
    s7_side_r.ux   <= s6_ux_r;
    s7_side_r.uy   <= s6_uy_r;
    s7_side_r.uz   <= s6_uz_r;
    s7_side_r.sumr <= s6_sumr_r;
  end

  assign out_valid = s7_v_r;
  assign out_rad   = s7_rad_r;
  assign out_side  = s7_side_r;

endmodule

>>> sv/scc_sqrt.sv
// pipelined floor square root, two result bits per stage
// depends on scc_pkg
module scc_sqrt import scc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [RAD_W-1:0] in_rad,
  input  scc_side_t        in_side,
  output logic             out_valid,
  output logic [SUM_W-1:0] out_root,
  output scc_side_t        out_side
);

  localparam int NS  = SUM_W / 2;
  localparam int REM = SUM_W + 4;

  typedef struct packed {
    logic [REM-1:0]   rem;
    logic [SUM_W-1:0] root;
    logic [RAD_W-1:0] rad;
  } sq_state_t;

  function automatic sq_state_t sq_step(input sq_state_t s);
    sq_state_t      n;
    logic [REM-1:0] cur, trial;
    cur   = {s.rem[REM-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    n.rad = {s.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      n.rem  = cur - trial;
      n.root = {s.root[SUM_W-2:0], 1'b1};
    end else begin
      n.rem  = cur;
      n.root = {s.root[SUM_W-2:0], 1'b0};
    end
    return n;
  endfunction

  logic      v_r    [NS];
  sq_state_t st_r   [NS];
  scc_side_t side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic      v_in;
    sq_state_t st_in;
    scc_side_t side_in;
    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign st_in   = '{rem: '0, root: '0, rad: in_rad};
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign st_in   = st_r[k-1];
      assign side_in = side_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      st_r[k]   <= sq_step(sq_step(st_in));
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_root  = st_r[NS-1].root;
  assign out_side  = side_r[NS-1];

endmodule

>>> sv/scc_div.sv
// pipelined three-lane restoring divider for the normal components
// depends on scc_pkg
module scc_div import scc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [SUM_W-1:0]   in_dist,
  input  scc_side_t          in_side,
  output logic               out_valid,
  output logic [SUM_W-1:0]   out_dist,
  output logic [FRAC_BITS:0] out_qx,
  output logic [FRAC_BITS:0] out_qy,
  output logic [FRAC_BITS:0] out_qz,
  output scc_side_t          out_side
);

  localparam int QW    = FRAC_BITS + 1;
  localparam int NS    = (QW + 1) / 2;
  localparam int RW    = SUM_W + 2;

  typedef struct packed {
    logic [RW-1:0] r;
    logic [QW-1:0] q;
  } dv_lane_t;

  typedef struct packed {
    dv_lane_t x;
    dv_lane_t y;
    dv_lane_t z;
  } dv_state_t;

  function automatic dv_lane_t dv_step(input dv_lane_t s, input logic [SUM_W-1:0] d);
    dv_lane_t      n;
    logic [RW-1:0] dw, rs;
    logic          ge;
    dw  = {2'b00, d};
    ge  = s.r >= dw;
    rs  = ge ? s.r - dw : s.r;
    n.r = {rs[RW-2:0], 1'b0};
    n.q = {s.q[QW-2:0], ge};
    return n;
  endfunction

  function automatic dv_state_t dv_all(input dv_state_t s, input logic [SUM_W-1:0] d);
    dv_state_t n;
    n.x = dv_step(s.x, d);
    n.y = dv_step(s.y, d);
    n.z = dv_step(s.z, d);
    return n;
  endfunction

  logic             v_r    [NS];
  logic [SUM_W-1:0] d_r    [NS];
  dv_state_t        st_r   [NS];
  scc_side_t        side_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic             v_in;
    logic [SUM_W-1:0] d_in;
    dv_state_t        st_in, st_mid, st_out;
    scc_side_t        side_in;
    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign d_in    = in_dist;
      assign st_in   = '{x: '{r: {2'b00, in_side.ux}, q: '0},
                         y: '{r: {2'b00, in_side.uy}, q: '0},
                         z: '{r: {2'b00, in_side.uz}, q: '0}};
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign d_in    = d_r[k-1];
      assign st_in   = st_r[k-1];
      assign side_in = side_r[k-1];
    end
    assign st_mid = dv_all(st_in, d_in);
    // the last stage takes a single step when the quotient width is odd
    if (2 * k + 1 < QW) begin : g_two
      assign st_out = dv_all(st_mid, d_in);
    end else begin : g_one
      assign st_out = st_mid;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_in;
      end
      d_r[k]    <= d_in;
      st_r[k]   <= st_out;
      side_r[k] <= side_in;
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_dist  = d_r[NS-1];
  assign out_qx    = st_r[NS-1].x.q;
  assign out_qy    = st_r[NS-1].y.q;
  assign out_qz    = st_r[NS-1].z.q;
  assign out_side  = side_r[NS-1];

endmodule

>>> sv/scc_checker.sv
// port-level checker for the sphere capsule contact core, bound to the top level
// depends on scc_pkg and the assertion macro header
`include "sphere_capsule_contact_core_assert.svh"

module scc_bind_checker import scc_pkg::*; #(
  parameter int COORD_WIDTH = COORD_W_DEF,
  parameter int FRAC_BITS   = FRAC_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic [1:0]                    in_func,
  input logic signed [COORD_WIDTH-1:0] in_a_x,
  input logic signed [COORD_WIDTH-1:0] in_a_y,
  input logic signed [COORD_WIDTH-1:0] in_a_z,
  input logic [LEN_W-1:0]              in_a_radius,
  input logic [LEN_W-1:0]              in_a_length,
  input logic signed [COORD_WIDTH-1:0] in_b_x,
  input logic signed [COORD_WIDTH-1:0] in_b_y,
  input logic signed [COORD_WIDTH-1:0] in_b_z,
  input logic [LEN_W-1:0]              in_b_radius,
  input logic [LEN_W-1:0]              in_b_length,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [THR_W-1:0]              cfg_data,
  input logic                          out_valid,
  input logic                          out_hit,
  input logic signed [FRAC_BITS+1:0]   out_normal_x,
  input logic signed [FRAC_BITS+1:0]   out_normal_y,
  input logic signed [FRAC_BITS+1:0]   out_normal_z,
  input logic [LEN_W-1:0]              out_depth
);

  localparam int NW = FRAC_BITS + 2;

  `SCC_ASSERT_ALWAYS(a_never_busy, !busy && cfg_ready, "core refused a word")
  `SCC_ASSERT_IMPL(a_miss_zero, out_valid && !out_hit, out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0 && out_depth == '0, "miss word carries nonzero fields")
  `SCC_ASSERT_IMPL(a_nx_range, out_valid, out_normal_x[NW-1:NW-2] != 2'b10, "normal x beyond unit range")
  `SCC_ASSERT_IMPL(a_nz_range, out_valid && out_hit, out_normal_z[NW-1:NW-2] != 2'b10, "normal z beyond unit range")

endmodule

bind sphere_capsule_contact_core scc_bind_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_scc_checker (.*);

>>> tb/scc_checker.sv
// checker for the sphere capsule contact core: watches start, cfg and out channels
// predicts each contact result and compares field by field; depends on scc_pkg
`timescale 1ns / 1ps
module scc_checker import scc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_func,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic [LEN_W-1:0]  in_a_radius,
  input  logic [LEN_W-1:0]  in_a_length,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  input  logic [LEN_W-1:0]  in_b_radius,
  input  logic [LEN_W-1:0]  in_b_length,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [THR_W-1:0]  cfg_data,
  input  logic              out_valid,
  input  logic              out_hit,
  input  logic signed [17:0] out_normal_x,
  input  logic signed [17:0] out_normal_y,
  input  logic signed [17:0] out_normal_z,
  input  logic [LEN_W-1:0]  out_depth,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic        hit;
    logic [17:0] nx;
    logic [17:0] ny;
    logic [17:0] nz;
    logic [30:0] pen;
  } contact_t;

  contact_t contact_q[$];
  logic [THR_W-1:0] thresh;

  function automatic longint clamp_z(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [17:0] signed_norm(logic [63:0] u, logic [63:0] root_d, logic neg);
    longint n;
    n = longint'((u << 16) / root_d);
    if (neg) n = -n;
    return n[17:0];
  endfunction

  function automatic contact_t predict_contact(
    logic [1:0] fn, longint ax, longint ay, longint az, logic [63:0] ar, logic [63:0] al,
    longint bx, longint by, longint bz, logic [63:0] br, logic [63:0] bl,
    logic [THR_W-1:0] thr);
    contact_t r;
    longint t, sa, ea, sb, eb, ca, cb, dx, dy, dz;
    logic [63:0] la, lb, lim, sumr, d2, sq, root_d, pen, ux, uy, uz;
    logic dega, degb;
    r = '0;
    if (fn == FUNC_CS) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
      t = az; az = bz; bz = t;
      sq = ar; ar = br; br = sq;
      sq = al; al = bl; bl = sq;
      fn = FUNC_SC;
    end
    la = (fn == FUNC_CC) ? al : 0;
    lb = (fn == FUNC_SC || fn == FUNC_CC) ? bl : 0;
    sa = az - longint'(la >> 1);
    ea = sa + longint'(la);
    sb = bz - longint'(lb >> 1);
    eb = sb + longint'(lb);
    lim = 64'(thr) << 16;
    dega = (la * la) <= lim;
    degb = (lb * lb) <= lim;
    if (dega) begin
      ca = sa;
      cb = degb ? sb : clamp_z(sa, sb, eb);
    end else if (degb) begin
      cb = sb;
      ca = clamp_z(sb, sa, ea);
    end else begin
      cb = clamp_z(sa, sb, eb);
      ca = clamp_z(cb, sa, ea);
    end
    dx = bx - ax;
    dy = by - ay;
    dz = cb - ca;
    sumr = ar + br;
    ux = dx < 0 ? -dx : dx;
    uy = dy < 0 ? -dy : dy;
    uz = dz < 0 ? -dz : dz;
    if (ux > sumr || uy > sumr || uz > sumr) return r;
    d2 = ux * ux;
    sq = uy * uy;
    d2 = (d2 > ~64'd0 - sq) ? ~64'd0 : d2 + sq;
    sq = uz * uz;
    d2 = (d2 > ~64'd0 - sq) ? ~64'd0 : d2 + sq;
    if (d2 > sumr * sumr) return r;
    root_d = root_floor(d2);
    r.hit = 1'b1;
    if (root_d > 0) begin
      r.nx = signed_norm(ux, root_d, dx < 0);
      r.ny = signed_norm(uy, root_d, dy < 0);
      r.nz = signed_norm(uz, root_d, dz < 0);
    end else begin
      r.nz = 18'd65536;
    end
    pen = sumr - root_d;
    if (pen > 64'h7FFFFFFF) pen = 64'h7FFFFFFF;
    r.pen = pen[30:0];
    return r;
  endfunction

  assign pending = contact_q.size();

  always @(posedge clk) begin
    contact_t got;
    contact_t want;
    if (!rst_n) begin
      thresh <= THR_RESET;
      contact_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) thresh <= cfg_data;
      if (start && !busy)
        contact_q = {contact_q, predict_contact(in_func, in_a_x, in_a_y, in_a_z,
          64'(in_a_radius), 64'(in_a_length), in_b_x, in_b_y, in_b_z,
          64'(in_b_radius), 64'(in_b_length), thresh)};
      if (out_valid) begin
        got = {out_hit, out_normal_x, out_normal_y, out_normal_z, out_depth};
        if (contact_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %h", got);
        end else begin
          want = contact_q.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch hit %b/%b nx %0d/%0d ny %0d/%0d nz %0d/%0d pen %0d/%0d",
                want.hit, got.hit, $signed(want.nx), $signed(got.nx),
                $signed(want.ny), $signed(got.ny), $signed(want.nz), $signed(got.nz),
                want.pen, got.pen);
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
// top of the sphere capsule contact testbench: clock, reset, stimulus, verdict
// depends on scc_pkg, sphere_capsule_contact_core and scc_checker
`timescale 1ns / 1ps
module tb;
  import scc_pkg::*;

  logic clk = 0, rst_n = 0;
  logic start = 0, busy, cfg_valid = 0, cfg_ready, out_valid, out_hit;
  logic [1:0] in_func = 0;
  logic signed [31:0] in_a_x = 0, in_a_y = 0, in_a_z = 0, in_b_x = 0, in_b_y = 0, in_b_z = 0;
  logic [LEN_W-1:0] in_a_radius = 0, in_a_length = 0, in_b_radius = 0, in_b_length = 0;
  logic [THR_W-1:0] cfg_data = 0;
  logic signed [17:0] out_normal_x, out_normal_y, out_normal_z;
  logic [LEN_W-1:0] out_depth;
  int fail_count, pending;
  int idle_pct;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  sphere_capsule_contact_core dut (.*);
  scc_checker chk (.*);

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [30:0] rand_len();
    case ($urandom_range(0, 5))
      0: return 31'($urandom);
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 3));
      default: return 31'($urandom_range(0, 8 << 16));
    endcase
  endfunction

  task automatic send_word(logic [1:0] fn, logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
    logic [30:0] ar, logic [30:0] al, logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
    logic [30:0] br, logic [30:0] bl);
    while ($urandom_range(0, 99) < idle_pct) @(negedge clk);
    in_func = fn; in_a_x = ax; in_a_y = ay; in_a_z = az; in_a_radius = ar;
    in_a_length = al; in_b_x = bx; in_b_y = by; in_b_z = bz; in_b_radius = br;
    in_b_length = bl;
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 0;
  endtask

  task automatic send_random();
    logic [31:0] ax, ay, az;
    ax = rand_coord(); ay = rand_coord(); az = rand_coord();
    if ($urandom_range(0, 3) != 0)
      send_word(2'($urandom), ax, ay, az, rand_len(), rand_len(),
        ax + 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)),
        ay + 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16)),
        az + 32'($signed($urandom_range(0, 16 << 16)) - (8 << 16)),
        rand_len(), rand_len());
    else
      send_word(2'($urandom), ax, ay, az, 31'($urandom), 31'($urandom),
        rand_coord(), rand_coord(), rand_coord(), 31'($urandom), 31'($urandom));
  endtask

  task automatic drain_and_config(logic [THR_W-1:0] val);
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    cfg_data = val;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  initial begin
    scc_func_t f;
    idle_pct = 0;
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);
    f = f.first();
    do begin
      send_word(f, 0, 0, 0, 31'h10000, 31'h20000, 0, 0, 0, 31'h10000, 31'h20000);
      send_word(f, 32'h10000, 0, 0, 31'h10000, 31'h30000, 0, 32'h8000, 32'h40000,
        31'h8000, 31'h10000);
      send_word(f, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
        31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
        31'h7FFF_FFFF);
      send_word(f, 0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF, 1);
      send_word(f, 0, 0, 0, 0, 0, 32'h30000, 0, 0, 31'h10000, 0);
      f = f.next();
    end while (f != f.first());
    drain_and_config(17'h1FFFF);
    idle_pct = 12;
    repeat (300) send_random();
    drain_and_config(0);
    idle_pct = 57;
    repeat (300) send_random();
    drain_and_config(17'h10000);
    idle_pct = 0;
    repeat (200) send_random();
    drain_and_config(THR_RESET);
    repeat (130) send_random();
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/scc_pkg.sv
sv/scc_front.sv
sv/scc_sqrt.sv
sv/scc_div.sv
sv/sphere_capsule_contact_core.sv
sv/scc_checker.sv
tb/scc_checker.sv
tb/tb.sv
